[hw/rtl/vcrf_pkg.sv]
package vcrf_pkg;

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned EXT_COUNT = 15;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  localparam logic [5:0] ADDR_CR1      = 6'h11;
  localparam logic [5:0] ADDR_RASTER   = 6'h12;
  localparam logic [5:0] ADDR_CR2      = 6'h16;
  localparam logic [5:0] ADDR_MEMPTR   = 6'h18;
  localparam logic [5:0] ADDR_IRQ      = 6'h19;
  localparam logic [5:0] ADDR_IRQ_EN   = 6'h1A;
  localparam logic [5:0] ADDR_SS_HIT   = 6'h1E;
  localparam logic [5:0] ADDR_SB_HIT   = 6'h1F;
  localparam logic [5:0] ADDR_COLOR_LO = 6'h20;
  localparam logic [5:0] ADDR_COLOR_HI = 6'h2E;

  localparam logic [8:0]  LINE_FIRST_DMA = 9'h030;
  localparam logic [8:0]  LINE_LAST_DMA  = 9'h0F7;
  localparam logic [15:0] BITMAP_MASK    = 16'hF9FF;
  localparam logic [15:0] ROM_HIGH_HALF  = 16'h0800;
  localparam logic [7:0]  UNUSED_READ    = 8'hFF;
  localparam logic [7:0]  CR2_ONES       = 8'hC0;
  localparam logic [7:0]  MEMPTR_ONES    = 8'h01;
  localparam logic [7:0]  IRQ_ONES       = 8'h70;
  localparam logic [7:0]  NIBBLE_ONES    = 8'hF0;

  localparam logic [7:0] CR1_RESET    = 8'h9B;
  localparam logic [7:0] CR2_RESET    = 8'h08;
  localparam logic [7:0] MEMPTR_RESET = 8'h14;
  localparam logic [7:0] IRQ_RESET    = 8'h0F;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] reg_address;
    logic [7:0] write_data;
    logic [8:0] raster_line;
    logic       clear_den_latch;
    logic [3:0] raise_irq_bits;
    logic [7:0] raise_sprite_hits;
    logic [7:0] raise_background_hits;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        badline;
    logic [8:0]  raster_compare;
    logic [15:0] video_matrix_addr;
    logic [15:0] charset_addr;
    logic        charset_in_rom;
    logic [15:0] bitmap_addr;
    logic [3:0]  irq_flags;
  } out_word_t;

  typedef struct packed {
    logic [15:0] video_matrix_addr;
    logic [15:0] charset_addr;
    logic        charset_in_rom;
    logic [15:0] bitmap_addr;
  } base_addr_t;

  function automatic logic [7:0] reg_reset(input logic [4:0] idx);
    logic [7:0] v;
    v = 8'h00;
    if ({1'b0, idx} == ADDR_CR1) v = CR1_RESET;
    if ({1'b0, idx} == ADDR_CR2) v = CR2_RESET;
    if ({1'b0, idx} == ADDR_MEMPTR) v = MEMPTR_RESET;
    if ({1'b0, idx} == ADDR_IRQ) v = IRQ_RESET;
    return v;
  endfunction

endpackage

[hw/rtl/vcrf_addr_decode.sv]
module vcrf_addr_decode
  import vcrf_pkg::*;
(
  input  logic [1:0] bank_select,
  input  logic [7:0] memptr,
  input  logic [7:0] cr1,
  output base_addr_t bases
);

  logic [2:0]  cs;
  logic        rom;
  logic [15:0] bm;

  assign cs  = memptr[3:1];
  assign rom = !bank_select[0] && (cs == 3'd2 || cs == 3'd3);
  assign bm  = {bank_select, memptr[3], 13'b0};

  always_comb begin
    bases.video_matrix_addr = {bank_select, memptr[7:4], 10'b0};
    bases.charset_in_rom    = rom;
    if (rom) begin
      bases.charset_addr = (cs == 3'd3) ? ROM_HIGH_HALF : 16'h0000;
    end else begin
      bases.charset_addr = {bank_select, cs, 11'b0};
    end
    bases.bitmap_addr = (cr1[6:5] == 2'b11) ? (bm & BITMAP_MASK) : bm;
  end

endmodule

[hw/rtl/vcrf_regfile.sv]
module vcrf_regfile
  import vcrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  in_word_t   req,
  input  logic [1:0] bank_select,
  output logic       done,
  output out_word_t  result
);

  logic [7:0] regs      [REG_COUNT];
  logic [7:0] regs_next [REG_COUNT];
  logic [3:0] ext       [EXT_COUNT];
  logic [3:0] ext_next  [EXT_COUNT];
  logic       den_latch;
  logic       den_latch_next;
  logic [8:0] raster_cmp;
  logic [8:0] raster_cmp_next;

  logic [7:0] rd;
  logic       bad;
  logic [5:0] a;
  logic [7:0] d;
  logic [8:0] line;
  logic [7:0] v;
  base_addr_t bases;

  assign a    = req.reg_address;
  assign d    = req.write_data;
  assign line = req.raster_line;
  assign v    = regs[a[4:0]];

  always_comb begin
    regs_next       = regs;
    ext_next        = ext;
    den_latch_next  = den_latch;
    raster_cmp_next = raster_cmp;
    rd              = 8'h00;
    bad             = 1'b0;
    if (req_valid) begin
      if (req.clear_den_latch) den_latch_next = 1'b0;
      case (req.cmd)
        CMD_READ: begin
          if (a == ADDR_CR1) begin
            rd = {line[8], v[6:0]};
          end else if (a == ADDR_RASTER) begin
            rd = line[7:0];
          end else if (a == ADDR_CR2) begin
            rd = v | CR2_ONES;
          end else if (a == ADDR_MEMPTR) begin
            rd = v | MEMPTR_ONES;
          end else if (a == ADDR_IRQ) begin
            rd = v | IRQ_ONES;
          end else if (a == ADDR_IRQ_EN) begin
            rd = v | NIBBLE_ONES;
          end else if (a == ADDR_SS_HIT || a == ADDR_SB_HIT) begin
            rd = v;
            regs_next[a[4:0]] = 8'h00;
          end else if (a inside {[ADDR_COLOR_LO:ADDR_COLOR_HI]}) begin
            rd = {4'hF, ext[a[3:0]]};
          end else if (a > ADDR_COLOR_HI) begin
            rd = UNUSED_READ;
          end else begin
            rd = v;
          end
        end
        CMD_WRITE: begin
          if (a == ADDR_CR1) begin
            regs_next[a[4:0]] = d;
            raster_cmp_next[8] = d[7];
            if (line == LINE_FIRST_DMA && d[4]) den_latch_next = 1'b1;
            bad = den_latch_next && line >= LINE_FIRST_DMA && line <= LINE_LAST_DMA &&
                  line[2:0] == d[2:0];
          end else if (a == ADDR_RASTER) begin
            regs_next[a[4:0]] = d;
            raster_cmp_next[7:0] = d;
          end else if (a == ADDR_IRQ) begin
            regs_next[a[4:0]] = v & {4'h0, ~d[3:0]};
          end else if (a == ADDR_IRQ_EN) begin
            regs_next[a[4:0]] = {4'h0, d[3:0]};
          end else if (a == ADDR_SS_HIT || a == ADDR_SB_HIT) begin
            regs_next[a[4:0]] = 8'h00;
          end else if (a inside {[ADDR_COLOR_LO:ADDR_COLOR_HI]}) begin
            ext_next[a[3:0]] = d[3:0];
          end else if (a < ADDR_COLOR_LO) begin
            regs_next[a[4:0]] = d;
          end
        end
        CMD_EVENT: begin
          regs_next[ADDR_IRQ[4:0]]    = regs[ADDR_IRQ[4:0]] | {4'h0, req.raise_irq_bits};
          regs_next[ADDR_SS_HIT[4:0]] = regs[ADDR_SS_HIT[4:0]] | req.raise_sprite_hits;
          regs_next[ADDR_SB_HIT[4:0]] = regs[ADDR_SB_HIT[4:0]] | req.raise_background_hits;
        end
        default: begin
        end
      endcase
    end
  end

  vcrf_addr_decode u_decode (
    .bank_select (bank_select),
    .memptr      (regs_next[ADDR_MEMPTR[4:0]]),
    .cr1         (regs_next[ADDR_CR1[4:0]]),
    .bases       (bases)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) regs[i] <= reg_reset(5'(i));
      for (int i = 0; i < EXT_COUNT; i++) ext[i] <= 4'h0;
      den_latch  <= 1'b0;
      raster_cmp <= 9'h000;
      done       <= 1'b0;
    end else begin
      regs       <= regs_next;
      ext        <= ext_next;
      den_latch  <= den_latch_next;
      raster_cmp <= raster_cmp_next;
      done       <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      result.read_data         <= rd;
      result.badline           <= bad;
      result.raster_compare    <= raster_cmp_next;
      result.video_matrix_addr <= bases.video_matrix_addr;
      result.charset_addr      <= bases.charset_addr;
      result.charset_in_rom    <= bases.charset_in_rom;
      result.bitmap_addr       <= bases.bitmap_addr;
      result.irq_flags         <= regs_next[ADDR_IRQ[4:0]][3:0];
    end
  end

endmodule

[hw/rtl/video_chip_register_file_unit.sv]
// Register interface of a video chip: bus reads and writes to 32 byte and
// 15 4-bit colour registers; event words raise IRQ and collision bits.
// Input channel: a word is taken at a clock edge where start is high and
// busy is low. busy is always low, so a word may arrive in every cycle.
// The word is captured in an input register, decoded and applied to the
// register file in the next cycle, and its result word is loaded into the
// result register at the end of that cycle.
// Output channel: done is high for exactly one cycle with the result word;
// each word passes the input register, then the result register; one word per
// clock. The receiver cannot stall, so results never wait.
// Configuration: cfg_we writes cfg_wdata into the 2-bit video bank select
// at the next edge; write it only while no word is in flight.
// Reset (synchronous, rst high) restores the register file defaults,
// clears the raster compare line, display-enable latch and bank select,
// and drops any word in flight.
module video_chip_register_file_unit
  import vcrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_word_t   request,
  output logic       done,
  output out_word_t  result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  logic       req_valid;
  in_word_t   req;
  logic [1:0] bank_select;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid   <= 1'b0;
      bank_select <= 2'd0;
    end else begin
      req_valid <= start && !busy;
      if (cfg_we) bank_select <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req <= request;
  end

  vcrf_regfile u_regfile (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .bank_select (bank_select),
    .done        (done),
    .result      (result)
  );

endmodule

[bench/vcrf_checker.sv]
`timescale 1ns / 100ps

module vcrf_checker
  import vcrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  in_word_t   request,
  input  logic       done,
  input  out_word_t  result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  output int         errors,
  output int         outstanding
);

  logic [7:0] regs [64];
  logic [8:0] cmp_line;
  logic       den;
  logic [1:0] bank;

  out_word_t  outcome_q [$];
  out_word_t  want_w;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic out_word_t bus_access_outcome(input in_word_t w);
    out_word_t  o;
    logic [5:0] a;
    logic [7:0] d;
    logic [8:0] line;
    logic [7:0] r18;
    logic [15:0] base;
    a = w.reg_address;
    d = w.write_data;
    line = w.raster_line;
    o = '0;
    if (w.clear_den_latch) den = 1'b0;
    case (w.cmd)
      CMD_READ: begin
        case (a)
          ADDR_CR1: o.read_data = {line[8], regs[a][6:0]};
          ADDR_RASTER: o.read_data = line[7:0];
          ADDR_CR2: o.read_data = regs[a] | CR2_ONES;
          ADDR_MEMPTR: o.read_data = regs[a] | MEMPTR_ONES;
          ADDR_IRQ: o.read_data = regs[a] | IRQ_ONES;
          ADDR_IRQ_EN: o.read_data = regs[a] | NIBBLE_ONES;
          ADDR_SS_HIT, ADDR_SB_HIT: begin
            o.read_data = regs[a];
            regs[a] = 8'h00;
          end
          default: begin
            if (a >= ADDR_COLOR_LO && a <= ADDR_COLOR_HI) o.read_data = regs[a] | NIBBLE_ONES;
            else if (a > ADDR_COLOR_HI) o.read_data = UNUSED_READ;
            else o.read_data = regs[a];
          end
        endcase
      end
      CMD_WRITE: begin
        case (a)
          ADDR_CR1: begin
            regs[a] = d;
            cmp_line[8] = d[7];
            if (line == LINE_FIRST_DMA && d[4]) den = 1'b1;
            o.badline = den && line >= LINE_FIRST_DMA && line <= LINE_LAST_DMA &&
                        line[2:0] == d[2:0];
          end
          ADDR_RASTER: begin
            regs[a] = d;
            cmp_line[7:0] = d;
          end
          ADDR_IRQ: regs[a] = regs[a] & {4'h0, ~d[3:0]};
          ADDR_IRQ_EN: regs[a] = {4'h0, d[3:0]};
          ADDR_SS_HIT, ADDR_SB_HIT: regs[a] = 8'h00;
          default: begin
            if (a >= ADDR_COLOR_LO && a <= ADDR_COLOR_HI) regs[a] = {4'h0, d[3:0]};
            else if (a < ADDR_COLOR_LO) regs[a] = d;
          end
        endcase
      end
      CMD_EVENT: begin
        regs[ADDR_IRQ] = regs[ADDR_IRQ] | {4'h0, w.raise_irq_bits};
        regs[ADDR_SS_HIT] = regs[ADDR_SS_HIT] | w.raise_sprite_hits;
        regs[ADDR_SB_HIT] = regs[ADDR_SB_HIT] | w.raise_background_hits;
      end
      default: ;
    endcase
    base = {bank, 14'h0000};
    r18 = regs[ADDR_MEMPTR];
    if (!bank[0] && r18[3:1] == 3'd2) begin
      o.charset_in_rom = 1'b1;
      o.charset_addr = 16'h0000;
    end else if (!bank[0] && r18[3:1] == 3'd3) begin
      o.charset_in_rom = 1'b1;
      o.charset_addr = ROM_HIGH_HALF;
    end else begin
      o.charset_addr = base + {2'b00, r18[3:1], 11'h000};
    end
    o.bitmap_addr = base | {2'b00, r18[3], 13'h0000};
    if (regs[ADDR_CR1][6:5] == 2'b11) o.bitmap_addr = o.bitmap_addr & BITMAP_MASK;
    o.video_matrix_addr = base + {2'b00, r18[7:4], 10'h000};
    o.raster_compare = cmp_line;
    o.irq_flags = regs[ADDR_IRQ][3:0];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (regs[i]) regs[i] = 8'h00;
      regs[ADDR_CR1] = CR1_RESET;
      regs[ADDR_CR2] = CR2_RESET;
      regs[ADDR_MEMPTR] = MEMPTR_RESET;
      regs[ADDR_IRQ] = IRQ_RESET;
      cmp_line = '0;
      den = 1'b0;
      bank = 2'd0;
      outcome_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) bank = cfg_wdata;
      if (done) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, result);
          errors++;
        end else begin
          want_w = outcome_q.pop_front();
          check_field("read_data", want_w.read_data, result.read_data);
          check_field("badline", want_w.badline, result.badline);
          check_field("raster_compare", want_w.raster_compare, result.raster_compare);
          check_field("video_matrix_addr", want_w.video_matrix_addr, result.video_matrix_addr);
          check_field("charset_addr", want_w.charset_addr, result.charset_addr);
          check_field("charset_in_rom", want_w.charset_in_rom, result.charset_in_rom);
          check_field("bitmap_addr", want_w.bitmap_addr, result.bitmap_addr);
          check_field("irq_flags", want_w.irq_flags, result.irq_flags);
        end
      end
      if (start && !busy) outcome_q.push_back(bus_access_outcome(request));
      outstanding <= outstanding + int'(start && !busy) - int'(done);
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import vcrf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 258;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  in_word_t   request = '0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;
  logic       busy;
  logic       done;
  out_word_t  result;
  int         errors;
  int         outstanding;
  int         cycles = 0;
  bit         gaps_on = 1'b1;

  video_chip_register_file_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  vcrf_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL video_chip_register_file_unit");
      $finish;
    end
  end

  function automatic in_word_t bus_word(input logic [1:0] cmd, input logic [5:0] a,
                                        input logic [7:0] d, input logic [8:0] line,
                                        input logic clr, input logic [3:0] irq,
                                        input logic [7:0] ss, input logic [7:0] sb);
    in_word_t w;
    w.cmd = cmd;
    w.reg_address = a;
    w.write_data = d;
    w.raster_line = line;
    w.clear_den_latch = clr;
    w.raise_irq_bits = irq;
    w.raise_sprite_hits = ss;
    w.raise_background_hits = sb;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (gaps_on && $urandom_range(99) < 5) begin
      gap = $urandom_range(3, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t    w;
    int unsigned pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(bus_word(CMD_READ, ADDR_CR1, 8'h00, 9'h1FF, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, ADDR_RASTER, 8'hFF, 9'h0AB, 1'b0, 4'hF, 8'hFF, 8'hFF));
    send_word(bus_word(CMD_READ, ADDR_CR2, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, ADDR_MEMPTR, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, ADDR_IRQ, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, ADDR_IRQ_EN, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, ADDR_COLOR_LO, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, ADDR_COLOR_HI, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, 6'h2F, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, 6'h3F, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_WRITE, ADDR_CR1, 8'hF8, 9'h030, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_WRITE, ADDR_RASTER, 8'hFF, 9'h0F7, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_WRITE, ADDR_MEMPTR, 8'h06, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_WRITE, ADDR_MEMPTR, 8'hFE, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_EVENT, 6'h00, 8'h00, 9'h000, 1'b1, 4'hF, 8'hFF, 8'hFF));
    send_word(bus_word(CMD_READ, ADDR_SS_HIT, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, ADDR_SB_HIT, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_READ, ADDR_SS_HIT, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_WRITE, ADDR_IRQ, 8'h05, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_WRITE, ADDR_IRQ_EN, 8'hFF, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_WRITE, ADDR_COLOR_LO, 8'hFF, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_WRITE, 6'h3F, 8'hFF, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_EVENT, 6'h00, 8'h00, 9'h000, 1'b0, 4'h3, 8'h81, 8'h18));
    send_word(bus_word(CMD_WRITE, ADDR_SS_HIT, 8'h00, 9'h000, 1'b0, 4'h0, 8'h00, 8'h00));
    send_word(bus_word(CMD_UNUSED, ADDR_CR1, 8'hFF, 9'h1FF, 1'b1, 4'hF, 8'hFF, 8'hFF));

    for (int p = 0; p < 6; p++) begin
      drain_results();
      cfg_we <= 1'b1;
      cfg_wdata <= 2'(3 - p);
      @(posedge clk);
      cfg_we <= 1'b0;
      gaps_on = (p != 2);
      repeat (PHASE_WORDS) begin
        pick = $urandom_range(99);
        w.cmd = pick < 40 ? CMD_WRITE : pick < 75 ? CMD_READ : pick < 95 ? CMD_EVENT : CMD_UNUSED;
        if ($urandom_range(1)) begin
          case ($urandom_range(11))
            0: w.reg_address = ADDR_RASTER;
            1: w.reg_address = ADDR_CR2;
            2: w.reg_address = ADDR_MEMPTR;
            3: w.reg_address = ADDR_IRQ;
            4: w.reg_address = ADDR_IRQ_EN;
            5: w.reg_address = ADDR_SS_HIT;
            6: w.reg_address = ADDR_SB_HIT;
            7: w.reg_address = 6'($urandom_range(ADDR_COLOR_HI, ADDR_COLOR_LO));
            8: w.reg_address = 6'($urandom_range(63, ADDR_COLOR_HI + 1));
            default: w.reg_address = ADDR_CR1;
          endcase
        end else begin
          w.reg_address = 6'($urandom_range(63));
        end
        w.write_data = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 25) begin
          w.raster_line = LINE_FIRST_DMA;
        end else if (pick < 55) begin
          w.raster_line = 9'($urandom_range(LINE_LAST_DMA, LINE_FIRST_DMA));
        end else if (pick < 65) begin
          case ($urandom_range(4))
            0: w.raster_line = 9'h02F;
            1: w.raster_line = 9'h0F8;
            2: w.raster_line = 9'h1FF;
            3: w.raster_line = 9'h100;
            default: w.raster_line = 9'h000;
          endcase
        end else begin
          w.raster_line = 9'($urandom_range(511));
        end
        if ($urandom_range(1)) w.write_data[2:0] = w.raster_line[2:0];
        w.clear_den_latch = ($urandom_range(19) == 0);
        w.raise_irq_bits = 4'($urandom);
        w.raise_sprite_hits = 8'($urandom);
        w.raise_background_hits = 8'($urandom);
        send_word(w);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS video_chip_register_file_unit");
    end else begin
      $display("FAIL video_chip_register_file_unit");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/vcrf_pkg.sv
hw/rtl/vcrf_addr_decode.sv
hw/rtl/vcrf_regfile.sv
hw/rtl/video_chip_register_file_unit.sv
bench/vcrf_checker.sv
bench/tb_top.sv
